// File: src/mtet_pkg.sv
`default_nettype none
package mtet_pkg;

   // register index codes on the csr port
   localparam logic [2:0] REG_COUNTS_PER_REV  = 3'd0;
   localparam logic [2:0] REG_GEAR_RATIO      = 3'd1;
   localparam logic [2:0] REG_WHEEL_RADIUS    = 3'd2;
   localparam logic [2:0] REG_STALL_ENABLE    = 3'd3;
   localparam logic [2:0] REG_STALL_TOLERANCE = 3'd4;
   localparam logic [2:0] REG_STALL_LIMIT     = 3'd5;

   // register reset values
   localparam logic [14:0] CPR_RESET       = 15'd8192;
   localparam logic [7:0]  GEAR_RESET      = 8'd19;
   localparam logic [9:0]  RADIUS_RESET    = 10'd0;
   localparam logic        STALL_EN_RESET  = 1'b0;
   localparam logic [12:0] TOLERANCE_RESET = 13'd10;
   localparam logic [15:0] LIMIT_RESET     = 16'd256;

   // arithmetic constants
   localparam logic [16:0]        DEG_SCALE   = 17'd92160;  // 360 * 256
   localparam logic signed [14:0] LS_SCALE    = 15'sd6863;  // 2*pi/60 in 1/65536
   localparam logic [7:0]         DIV10_RECIP = 8'd205;     // n/10 = n*205 >> 11
   localparam logic [16:0]        MOVING_MAX  = 17'd131071;

   // divider lengths in bits
   localparam logic [5:0] RPM_DIV_BITS   = 6'd16;
   localparam logic [5:0] ANGLE_DIV_BITS = 6'd48;

   // sequencer states
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_PREP  = 10'b0000000010,
      S_DIVQ  = 10'b0000000100,
      S_MUL1  = 10'b0000001000,
      S_MUL2  = 10'b0000010000,
      S_DIVR  = 10'b0000100000,
      S_LOADA = 10'b0001000000,
      S_DIVA  = 10'b0010000000,
      S_FIN   = 10'b0100000000,
      S_SPARE = 10'b1000000000
   } state_type;

   // 32 bit signed add of a step, saturating at the signed limits
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [17:0] s);
      logic [32:0] sum;
      begin
         sum = {a[31], a} + {{15{s[17]}}, s};
         if (sum[32] != sum[31]) begin
            sat_add32 = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            sat_add32 = sum[31:0];
         end
      end
   endfunction

endpackage
`default_nettype wire

// File: src/multiturn_encoder_tracker_unit.sv
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_type, req_raw_position, req_speed_rpm
// rsp       out        rsp_valid / rsp_ready  counts, angles, accel, speed, stalled
// csr       in         csr_we                 csr_index, csr_wdata
//
// For a feedback word, one shared restoring divider retires one quotient bit a cycle,
// 16 bits for rpm/gear and 48 bits for each of the two angles.
// A zero request skips the divider. req_ready is high only while the sequencer is idle.
// The result sits in an output register; the next word is taken while it waits, and
// the sequencer holds before its final write until the register is free.
// Reset is synchronous and active high; it clears control, history and configuration registers.
module multiturn_encoder_tracker_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic [13:0]        req_raw_position,
   input  wire logic signed [15:0] req_speed_rpm,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_record_count,
   output logic signed [31:0]      rsp_actual_count,
   output logic signed [47:0]      rsp_record_angle,
   output logic signed [47:0]      rsp_actual_angle,
   output logic signed [16:0]      rsp_accel_rpm,
   output logic signed [27:0]      rsp_linear_speed,
   output logic signed [28:0]      rsp_linear_accel,
   output logic                    rsp_stalled,
   // configuration port
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   // configuration registers
   logic [14:0] cfg_cpr_ff, cfg_cpr_in;
   logic [7:0]  cfg_gear_ff, cfg_gear_in;
   logic [9:0]  cfg_radius_ff, cfg_radius_in;
   logic        cfg_stall_en_ff, cfg_stall_en_in;
   logic [12:0] cfg_tol_ff, cfg_tol_in;
   logic [15:0] cfg_limit_ff, cfg_limit_in;

   // sequencer and shared divider
   mtet_pkg::state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        zero_ff, zero_in;
   logic [22:0] rem_ff, rem_in;
   logic [47:0] dvd_ff, dvd_in;
   logic [22:0] dsr_ff, dsr_in;
   logic [22:0] angdiv_ff, angdiv_in;

   // captured word and working values
   logic [13:0]        pos_ff, pos_in;
   logic [15:0]        rpm_ff, rpm_in;
   logic [6:0]         r10_ff, r10_in;
   logic signed [24:0] prod1_ff, prod1_in;
   logic [16:0]        accel_ff, accel_in;
   logic [27:0]        ls_ff, ls_in;
   logic [28:0]        laccel_ff, laccel_in;
   logic               stalled_ff, stalled_in;
   logic [47:0]        rec_angle_ff, rec_angle_in;

   // history
   logic [13:0] prev_position_ff, prev_position_in;
   logic [15:0] prev_rpm_ff, prev_rpm_in;
   logic [27:0] prev_ls_ff, prev_ls_in;
   logic [31:0] record_accum_ff, record_accum_in;
   logic [31:0] actual_accum_ff, actual_accum_in;
   logic        seen_first_ff, seen_first_in;
   logic [16:0] moving_count_ff, moving_count_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_rec_count_ff, out_rec_count_in;
   logic [31:0] out_act_count_ff, out_act_count_in;
   logic [47:0] out_rec_angle_ff, out_rec_angle_in;
   logic [47:0] out_act_angle_ff, out_act_angle_in;
   logic [16:0] out_accel_ff, out_accel_in;
   logic [27:0] out_ls_ff, out_ls_in;
   logic [28:0] out_laccel_ff, out_laccel_in;
   logic        out_stalled_ff, out_stalled_in;

   // combinational helpers
   logic               req_fire;
   logic               out_free;
   logic [14:0]        cpr_eff;
   logic [7:0]         gear_eff;
   logic [13:0]        prev_eff;
   logic [31:0]        act_base;
   logic signed [17:0] diff18, half18, cpr18, step_a, step;
   logic [17:0]        step_mag;
   logic [31:0]        rec_new, act_new;
   logic [16:0]        moving_new;
   logic [15:0]        rpm_mag;
   logic [17:0]        r10_prod;
   logic [23:0]        div_shift;
   logic [24:0]        div_diff;
   logic               div_fit;
   logic [22:0]        div_rem_next;
   logic [47:0]        div_dvd_next;
   logic signed [16:0] q_signed;
   logic signed [38:0] prod2;
   logic [27:0]        ls_val;
   logic [31:0]        rec_mag, act_mag;
   logic [48:0]        rec_scaled, act_scaled;
   logic [47:0]        quot_neg;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == mtet_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_comb begin
      cfg_cpr_in      = cfg_cpr_ff;
      cfg_gear_in     = cfg_gear_ff;
      cfg_radius_in   = cfg_radius_ff;
      cfg_stall_en_in = cfg_stall_en_ff;
      cfg_tol_in      = cfg_tol_ff;
      cfg_limit_in    = cfg_limit_ff;
      if (csr_we) begin
         case (csr_index)
            mtet_pkg::REG_COUNTS_PER_REV:  cfg_cpr_in      = csr_wdata[14:0];
            mtet_pkg::REG_GEAR_RATIO:      cfg_gear_in     = csr_wdata[7:0];
            mtet_pkg::REG_WHEEL_RADIUS:    cfg_radius_in   = csr_wdata[9:0];
            mtet_pkg::REG_STALL_ENABLE:    cfg_stall_en_in = csr_wdata[0];
            mtet_pkg::REG_STALL_TOLERANCE: cfg_tol_in      = csr_wdata[12:0];
            mtet_pkg::REG_STALL_LIMIT:     cfg_limit_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // step unwrap, saturating accumulate and stall count
   always_comb begin
      cpr_eff  = (cfg_cpr_ff < 15'd2) ? 15'd2 : cfg_cpr_ff;
      gear_eff = (cfg_gear_ff == 8'd0) ? 8'd1 : cfg_gear_ff;
      prev_eff = seen_first_ff ? prev_position_ff : pos_ff;
      act_base = seen_first_ff ? actual_accum_ff : {18'd0, pos_ff};
      diff18   = $signed({4'd0, pos_ff}) - $signed({4'd0, prev_eff});
      half18   = $signed({4'd0, cpr_eff[14:1]});
      cpr18    = $signed({3'd0, cpr_eff});
      step_a   = (diff18 < -half18) ? diff18 + cpr18 : diff18;
      step     = (step_a > half18) ? step_a - cpr18 : step_a;
      step_mag = step[17] ? 18'(-step) : 18'(step);
      rec_new  = mtet_pkg::sat_add32(record_accum_ff, step);
      act_new  = mtet_pkg::sat_add32(act_base, step);
      if (step_mag > {5'd0, cfg_tol_ff}) begin
         moving_new = (moving_count_ff != mtet_pkg::MOVING_MAX) ? moving_count_ff + 17'd1
                                                               : moving_count_ff;
      end else begin
         moving_new = 17'd0;
      end
      rpm_mag  = rpm_ff[15] ? 16'(-rpm_ff) : rpm_ff;
      r10_prod = cfg_radius_ff * mtet_pkg::DIV10_RECIP;
   end

   // shared restoring divider, one quotient bit a cycle
   always_comb begin
      div_shift    = {rem_ff, dvd_ff[47]};
      div_diff     = {1'b0, div_shift} - {2'd0, dsr_ff};
      div_fit      = !div_diff[24];
      div_rem_next = div_fit ? div_diff[22:0] : div_shift[22:0];
      div_dvd_next = {dvd_ff[46:0], div_fit};
   end

   // linear speed and angle dividend scaling
   always_comb begin
      q_signed   = rpm_ff[15] ? -$signed({1'b0, dvd_ff[15:0]}) : $signed({1'b0, dvd_ff[15:0]});
      prod2      = prod1_ff * mtet_pkg::LS_SCALE;
      ls_val     = prod2[35:8];
      rec_mag    = record_accum_ff[31] ? 32'(-record_accum_ff) : record_accum_ff;
      act_mag    = actual_accum_ff[31] ? 32'(-actual_accum_ff) : actual_accum_ff;
      rec_scaled = rec_mag * mtet_pkg::DEG_SCALE;
      act_scaled = act_mag * mtet_pkg::DEG_SCALE;
      quot_neg   = -dvd_ff;
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      zero_in          = zero_ff;
      rem_in           = rem_ff;
      dvd_in           = dvd_ff;
      dsr_in           = dsr_ff;
      angdiv_in        = angdiv_ff;
      pos_in           = pos_ff;
      rpm_in           = rpm_ff;
      r10_in           = r10_ff;
      prod1_in         = prod1_ff;
      accel_in         = accel_ff;
      ls_in            = ls_ff;
      laccel_in        = laccel_ff;
      stalled_in       = stalled_ff;
      rec_angle_in     = rec_angle_ff;
      prev_position_in = prev_position_ff;
      prev_rpm_in      = prev_rpm_ff;
      prev_ls_in       = prev_ls_ff;
      record_accum_in  = record_accum_ff;
      actual_accum_in  = actual_accum_ff;
      seen_first_in    = seen_first_ff;
      moving_count_in  = moving_count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      out_rec_count_in = out_rec_count_ff;
      out_act_count_in = out_act_count_ff;
      out_rec_angle_in = out_rec_angle_ff;
      out_act_angle_in = out_act_angle_ff;
      out_accel_in     = out_accel_ff;
      out_ls_in        = out_ls_ff;
      out_laccel_in    = out_laccel_ff;
      out_stalled_in   = out_stalled_ff;

      case (state_ff)
         mtet_pkg::S_IDLE: begin
            if (req_fire) begin
               pos_in = req_raw_position;
               rpm_in = req_speed_rpm;
               if (req_type) begin
                  // zero request clears counts and re-arms seeding
                  zero_in         = 1'b1;
                  record_accum_in = 32'd0;
                  actual_accum_in = 32'd0;
                  seen_first_in   = 1'b0;
                  state_in        = mtet_pkg::S_FIN;
               end else begin
                  zero_in  = 1'b0;
                  state_in = mtet_pkg::S_PREP;
               end
            end
         end
         mtet_pkg::S_PREP: begin
            // update history and start rpm / gear
            seen_first_in    = 1'b1;
            prev_position_in = pos_ff;
            record_accum_in  = rec_new;
            actual_accum_in  = act_new;
            accel_in         = {rpm_ff[15], rpm_ff} - {prev_rpm_ff[15], prev_rpm_ff};
            prev_rpm_in      = rpm_ff;
            if (cfg_stall_en_ff) begin
               moving_count_in = moving_new;
               stalled_in      = (moving_new > {1'b0, cfg_limit_ff});
            end else begin
               stalled_in = 1'b0;
            end
            r10_in    = r10_prod[17:11];
            angdiv_in = gear_eff * cpr_eff;
            dvd_in    = {rpm_mag, 32'd0};
            dsr_in    = {15'd0, gear_eff};
            rem_in    = 23'd0;
            cnt_in    = mtet_pkg::RPM_DIV_BITS;
            state_in  = mtet_pkg::S_DIVQ;
         end
         mtet_pkg::S_DIVQ: begin
            rem_in = div_rem_next;
            dvd_in = div_dvd_next;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = mtet_pkg::S_MUL1;
            end
         end
         mtet_pkg::S_MUL1: begin
            prod1_in = q_signed * $signed({1'b0, r10_ff});
            state_in = mtet_pkg::S_MUL2;
         end
         mtet_pkg::S_MUL2: begin
            // finish linear speed, start the record angle
            ls_in      = ls_val;
            laccel_in  = {ls_val[27], ls_val} - {prev_ls_ff[27], prev_ls_ff};
            prev_ls_in = ls_val;
            dvd_in     = rec_scaled[47:0];
            dsr_in     = angdiv_ff;
            rem_in     = 23'd0;
            cnt_in     = mtet_pkg::ANGLE_DIV_BITS;
            state_in   = mtet_pkg::S_DIVR;
         end
         mtet_pkg::S_DIVR: begin
            rem_in = div_rem_next;
            dvd_in = div_dvd_next;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = mtet_pkg::S_LOADA;
            end
         end
         mtet_pkg::S_LOADA: begin
            rec_angle_in = record_accum_ff[31] ? quot_neg : dvd_ff;
            dvd_in       = act_scaled[47:0];
            rem_in       = 23'd0;
            cnt_in       = mtet_pkg::ANGLE_DIV_BITS;
            state_in     = mtet_pkg::S_DIVA;
         end
         mtet_pkg::S_DIVA: begin
            rem_in = div_rem_next;
            dvd_in = div_dvd_next;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = mtet_pkg::S_FIN;
            end
         end
         mtet_pkg::S_FIN: begin
            // hand the word to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = mtet_pkg::S_IDLE;
               if (zero_ff) begin
                  out_rec_count_in = 32'd0;
                  out_act_count_in = 32'd0;
                  out_rec_angle_in = 48'd0;
                  out_act_angle_in = 48'd0;
                  out_accel_in     = 17'd0;
                  out_ls_in        = 28'd0;
                  out_laccel_in    = 29'd0;
                  out_stalled_in   = 1'b0;
               end else begin
                  out_rec_count_in = record_accum_ff;
                  out_act_count_in = actual_accum_ff;
                  out_rec_angle_in = rec_angle_ff;
                  out_act_angle_in = actual_accum_ff[31] ? quot_neg : dvd_ff;
                  out_accel_in     = accel_ff;
                  out_ls_in        = ls_ff;
                  out_laccel_in    = laccel_ff;
                  out_stalled_in   = stalled_ff;
               end
            end
         end
         default: begin
            state_in = mtet_pkg::S_IDLE;
         end
      endcase
   end

   // control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cpr_ff       <= mtet_pkg::CPR_RESET;
         cfg_gear_ff      <= mtet_pkg::GEAR_RESET;
         cfg_radius_ff    <= mtet_pkg::RADIUS_RESET;
         cfg_stall_en_ff  <= mtet_pkg::STALL_EN_RESET;
         cfg_tol_ff       <= mtet_pkg::TOLERANCE_RESET;
         cfg_limit_ff     <= mtet_pkg::LIMIT_RESET;
         state_ff         <= mtet_pkg::S_IDLE;
         cnt_ff           <= 6'd0;
         zero_ff          <= 1'b0;
         prev_position_ff <= 14'd0;
         prev_rpm_ff      <= 16'd0;
         prev_ls_ff       <= 28'd0;
         record_accum_ff  <= 32'd0;
         actual_accum_ff  <= 32'd0;
         seen_first_ff    <= 1'b0;
         moving_count_ff  <= 17'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_cpr_ff       <= cfg_cpr_in;
         cfg_gear_ff      <= cfg_gear_in;
         cfg_radius_ff    <= cfg_radius_in;
         cfg_stall_en_ff  <= cfg_stall_en_in;
         cfg_tol_ff       <= cfg_tol_in;
         cfg_limit_ff     <= cfg_limit_in;
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         zero_ff          <= zero_in;
         prev_position_ff <= prev_position_in;
         prev_rpm_ff      <= prev_rpm_in;
         prev_ls_ff       <= prev_ls_in;
         record_accum_ff  <= record_accum_in;
         actual_accum_ff  <= actual_accum_in;
         seen_first_ff    <= seen_first_in;
         moving_count_ff  <= moving_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff           <= rem_in;
      dvd_ff           <= dvd_in;
      dsr_ff           <= dsr_in;
      angdiv_ff        <= angdiv_in;
      pos_ff           <= pos_in;
      rpm_ff           <= rpm_in;
      r10_ff           <= r10_in;
      prod1_ff         <= prod1_in;
      accel_ff         <= accel_in;
      ls_ff            <= ls_in;
      laccel_ff        <= laccel_in;
      stalled_ff       <= stalled_in;
      rec_angle_ff     <= rec_angle_in;
      out_rec_count_ff <= out_rec_count_in;
      out_act_count_ff <= out_act_count_in;
      out_rec_angle_ff <= out_rec_angle_in;
      out_act_angle_ff <= out_act_angle_in;
      out_accel_ff     <= out_accel_in;
      out_ls_ff        <= out_ls_in;
      out_laccel_ff    <= out_laccel_in;
      out_stalled_ff   <= out_stalled_in;
   end

   // outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_count = $signed(out_rec_count_ff);
   assign rsp_actual_count = $signed(out_act_count_ff);
   assign rsp_record_angle = $signed(out_rec_angle_ff);
   assign rsp_actual_angle = $signed(out_act_angle_ff);
   assign rsp_accel_rpm    = $signed(out_accel_ff);
   assign rsp_linear_speed = $signed(out_ls_ff);
   assign rsp_linear_accel = $signed(out_laccel_ff);
   assign rsp_stalled      = out_stalled_ff;

   // zero request clears both counts and re-arms seeding
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type) |=>
         (record_accum_ff == 32'd0 && actual_accum_ff == 32'd0 && !seen_first_ff))
      else $error("zero request did not clear the counts");

   // a feedback word starts the sequencer
   a_feedback_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_type) |=> (state_ff == mtet_pkg::S_PREP))
      else $error("feedback word did not start the sequencer");

   // rpm division never runs longer than its width
   a_divq_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtet_pkg::S_DIVQ) |-> (cnt_ff != 6'd0 && cnt_ff <= mtet_pkg::RPM_DIV_BITS))
      else $error("rpm divider count out of range");

   // final write lands in the output register and frees the sequencer
   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtet_pkg::S_FIN && out_free) |=>
         (rsp_valid_ff && state_ff == mtet_pkg::S_IDLE))
      else $error("result word not loaded into output register");

endmodule
`default_nettype wire
